>>> hdl/ltl_pkg.sv
// Shared types, constants and byte classification helpers for the line token lexer.
// No dependencies; the lexer top level, the checker and the testbench import this package.
package ltl_pkg;

  // Token kinds as they appear on the result word.
  typedef enum logic [2:0] {
    KIND_IDENT    = 3'd0,
    KIND_EXTERN   = 3'd1,
    KIND_DEF      = 3'd2,
    KIND_INT      = 3'd3,
    KIND_DEC      = 3'd4,
    KIND_STR      = 3'd5,
    KIND_PUNC     = 3'd6,
    KIND_SYM_LONG = 3'd7
  } kind_t;

  // Keyword tracker codes: 1..6 walk "extern", 7..9 walk "def".
  localparam logic [3:0] KW_START       = 4'd0;
  localparam logic [3:0] KW_EXTERN_FULL = 4'd6;
  localparam logic [3:0] KW_DEF_FIRST   = 4'd7;
  localparam logic [3:0] KW_DEF_FULL    = 4'd9;
  localparam logic [3:0] KW_NONE        = 4'd15;

  localparam logic [62:0] ACC_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || c == CH_UNDER;
  endfunction

  // One step of the keyword prefix matcher. Full matches and misses hold.
  function automatic logic [3:0] kw_step(input logic [3:0] p, input logic [7:0] c);
    logic [3:0] r;
    r = p;
    case (p)
      KW_START: begin
        if (c == 8'h65) r = 4'd1;
        else if (c == 8'h64) r = KW_DEF_FIRST;
        else r = KW_NONE;
      end
      4'd1:         r = (c == 8'h78) ? 4'd2 : KW_NONE;
      4'd2:         r = (c == 8'h74) ? 4'd3 : KW_NONE;
      4'd3:         r = (c == 8'h65) ? 4'd4 : KW_NONE;
      4'd4:         r = (c == 8'h72) ? 4'd5 : KW_NONE;
      4'd5:         r = (c == 8'h6E) ? KW_EXTERN_FULL : KW_NONE;
      KW_DEF_FIRST: r = (c == 8'h65) ? 4'd8 : KW_NONE;
      4'd8:         r = (c == 8'h66) ? KW_DEF_FULL : KW_NONE;
      default:      r = p;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/ltl_in_if.sv
// Byte channel of the line token lexer: one line byte and its end-of-line mark per word.
// No dependencies.
interface ltl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_last;

  modport source (output valid, output ch, output line_last, input ready);
  modport sink   (input valid, input ch, input line_last, output ready);
endinterface

>>> hdl/ltl_out_if.sv
// Token channel of the line token lexer: one token description per word.
// No dependencies.
interface ltl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [11:0] start_res;
  logic [12:0] length;
  logic [62:0] int_value;
  logic [15:0] punc_text;

  modport source (output valid, output kind, output start_res, output length,
                  output int_value, output punc_text, input ready);
  modport sink   (input valid, input kind, input start_res, input length,
                  input int_value, input punc_text, output ready);
endinterface

>>> hdl/line_token_lexer.sv
// Line token lexer top level: byte classification, lexer state and the token register.
// Depends on ltl_pkg, ltl_in_if and ltl_out_if.

// The lexer takes one byte of a text line per cycle on the text channel and
// presents at most one token per byte on the token channel, registered in the
// cycle after the byte that ends it. Each byte is classified and the lexer
// state updated as it is accepted, so the sustained rate is one byte per clock;
// the only thing that holds the text channel back is a token that is still
// waiting in the output register and is not taken in the same cycle, whether
// or not the byte on offer would end a token. A byte marked line_last
// is lexed normally and then returns all state to reset, dropping any open
// token. Token positions count from zero at the start of each line and stop at
// LINE_MAX-1. There is no memory and no start-up pass after reset.
module line_token_lexer #(
  parameter int LINE_MAX = 4096
) (
  input logic clk,
  input logic rst,
  ltl_in_if.sink    text,
  ltl_out_if.source token
);
  import ltl_pkg::*;

  localparam int PW = $clog2(LINE_MAX);
  localparam logic [PW-1:0] POS_LAST = PW'(LINE_MAX - 1);

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_INT, M_DEC, M_STR, M_SYM
  } mode_t;

  mode_t       lex_mode, lex_mode_next;
  logic [PW-1:0] position, token_start, token_start_next;
  logic [7:0]  prev_byte;
  logic [62:0] int_accum, int_accum_next;
  logic [3:0]  keyword_progress, keyword_progress_next;
  logic [15:0] symbol_bytes, symbol_bytes_next;
  logic        comment_skip, comment_skip_next;

  logic        out_valid;
  kind_t       out_kind;
  logic [11:0] out_start;
  logic [12:0] out_length;
  logic [62:0] out_int;
  logic [15:0] out_punc;

  logic        accept;
  logic [7:0]  c;
  logic [PW-1:0] span;
  logic [31:0] span_w, span_p1, start_w;
  logic [66:0] acc_x10;
  logic        acc_sat;

  // Start of a new token as seen from idle.
  mode_t       si_mode;
  logic        si_skip;

  logic        emit;
  kind_t       emit_kind;
  logic [12:0] emit_length;
  logic [62:0] emit_int;
  logic [15:0] emit_punc;
  logic        restart;

  assign c       = text.ch;
  assign accept  = text.valid && text.ready;
  assign text.ready = !out_valid || token.ready;

  assign span    = position - token_start;
  assign span_w  = 32'(span);
  assign span_p1 = span_w + 32'd1;
  assign start_w = 32'(token_start);

  // Decimal accumulate as shift-and-add; saturate once the value passes the limit.
  assign acc_x10 = ({4'b0, int_accum} << 3) + ({4'b0, int_accum} << 1) + 67'(c[3:0]);
  assign acc_sat = acc_x10 > 67'(ACC_MAX);

  // Classify the byte as the first byte of a token.
  always_comb begin
    si_mode = M_IDLE;
    si_skip = 1'b0;
    if (is_alpha(c) || c == CH_UNDER) begin
      si_mode = M_IDENT;
    end else if (is_digit(c)) begin
      si_mode = M_INT;
    end else if (c == CH_QUOTE) begin
      si_mode = M_STR;
    end else if (c == CH_HASH) begin
      si_skip = 1'b1;
    end else if (c != CH_SPACE) begin
      si_mode = M_SYM;
    end
  end

  // Per-byte state update and token decision.
  always_comb begin
    lex_mode_next         = lex_mode;
    token_start_next      = token_start;
    int_accum_next        = int_accum;
    keyword_progress_next = keyword_progress;
    symbol_bytes_next     = symbol_bytes;
    comment_skip_next     = comment_skip;
    emit        = 1'b0;
    emit_kind   = KIND_IDENT;
    emit_length = span_w[12:0];
    emit_int    = '0;
    emit_punc   = '0;
    restart     = 1'b0;

    if (!comment_skip) begin
      case (lex_mode)
        M_IDENT: begin
          if (!is_word(c)) begin
            emit = 1'b1;
            if (keyword_progress == KW_EXTERN_FULL) emit_kind = KIND_EXTERN;
            else if (keyword_progress == KW_DEF_FULL) emit_kind = KIND_DEF;
            else emit_kind = KIND_IDENT;
            restart = 1'b1;
          end else begin
            keyword_progress_next = kw_step(keyword_progress, c);
          end
        end
        M_INT: begin
          if (c == CH_DOT) begin
            lex_mode_next = M_DEC;
          end else if (is_digit(c)) begin
            int_accum_next = acc_sat ? ACC_MAX : acc_x10[62:0];
          end else begin
            emit      = 1'b1;
            emit_kind = KIND_INT;
            emit_int  = int_accum;
            restart   = 1'b1;
          end
        end
        M_DEC: begin
          if (!is_digit(c)) begin
            emit      = 1'b1;
            emit_kind = KIND_DEC;
            restart   = 1'b1;
          end
        end
        M_STR: begin
          if (c == CH_QUOTE && prev_byte != CH_BACKSLASH) begin
            emit          = 1'b1;
            emit_kind     = KIND_STR;
            emit_length   = span_p1[12:0];
            lex_mode_next = M_IDLE;
          end
        end
        M_SYM: begin
          if (is_word(c) || c == CH_NEWLINE) begin
            emit      = 1'b1;
            emit_kind = (span_w > 32'd2) ? KIND_SYM_LONG : KIND_PUNC;
            emit_punc = symbol_bytes;
            restart   = 1'b1;
          end else if (span_w == 32'd1) begin
            symbol_bytes_next = symbol_bytes | {8'h00, c};
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase
    end

    // A byte that ends a non-string token, or comes in idle, is handled as a possible token start.
    if (restart) begin
      lex_mode_next    = si_mode;
      token_start_next = position;
      if (si_skip) comment_skip_next = 1'b1;
      case (si_mode)
        M_IDENT: keyword_progress_next = kw_step(KW_START, c);
        M_INT:   int_accum_next        = 63'(c[3:0]);
        M_SYM:   symbol_bytes_next     = {c, 8'h00};
        default: ;
      endcase
    end
  end

  // Lexer state and the token register.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode         <= M_IDLE;
      position         <= '0;
      token_start      <= '0;
      prev_byte        <= '0;
      int_accum        <= '0;
      keyword_progress <= KW_START;
      symbol_bytes     <= '0;
      comment_skip     <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        if (text.line_last) begin
          lex_mode         <= M_IDLE;
          position         <= '0;
          token_start      <= '0;
          prev_byte        <= '0;
          int_accum        <= '0;
          keyword_progress <= KW_START;
          symbol_bytes     <= '0;
          comment_skip     <= 1'b0;
        end else begin
          lex_mode         <= lex_mode_next;
          token_start      <= token_start_next;
          prev_byte        <= c;
          int_accum        <= int_accum_next;
          keyword_progress <= keyword_progress_next;
          symbol_bytes     <= symbol_bytes_next;
          comment_skip     <= comment_skip_next;
          if (position < POS_LAST) position <= position + PW'(1);
        end
        out_valid <= emit;
      end else if (token.ready) begin
        out_valid <= 1'b0;
      end
      if (accept && emit) begin
        out_kind   <= emit_kind;
        out_start  <= start_w[11:0];
        out_length <= emit_length;
        out_int    <= emit_int;
        out_punc   <= emit_punc;
      end
    end
  end

  assign token.valid     = out_valid;
  assign token.kind      = out_kind;
  assign token.start_res = out_start;
  assign token.length    = out_length;
  assign token.int_value = out_int;
  assign token.punc_text = out_punc;

endmodule

>>> hdl/ltl_checker.sv
// Port-level assertions for the line token lexer, bound to its top level.
// Depends on ltl_pkg and line_token_lexer.
module ltl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [12:0] length,
  input logic [62:0] int_value,
  input logic [15:0] punc_text
);
  import ltl_pkg::*;

  // Reset leaves no token pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("token valid after reset");

  // A token that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(length))
    else $error("stalled token changed or dropped");

  // Only integer tokens carry a value.
  a_int_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_INT |-> int_value == 63'd0)
    else $error("value on a non-integer token");

  // Only symbol tokens carry symbol bytes.
  a_punc_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PUNC && kind != KIND_SYM_LONG |-> punc_text == 16'd0)
    else $error("symbol bytes on a non-symbol token");

  // A punctuation token is at most two bytes long.
  a_punc_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_PUNC |-> length <= 13'd2)
    else $error("punctuation token too long");

endmodule

bind line_token_lexer ltl_checker u_ltl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (token.valid),
  .out_ready (token.ready),
  .kind      (token.kind),
  .length    (token.length),
  .int_value (token.int_value),
  .punc_text (token.punc_text)
);

>>> tb/sv/line_token_lexer_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for line_token_lexer: directed and random text lines in, tokens out.
// Depends on ltl_pkg, ltl_in_if, ltl_out_if and the line_token_lexer RTL.

import ltl_pkg::*;

// Scanner modes of the predictor.
typedef enum logic [2:0] {
  SCAN_IDLE,
  SCAN_IDENT,
  SCAN_INT,
  SCAN_DEC,
  SCAN_STR,
  SCAN_SYM
} scan_mode_t;

// One token word as it leaves the lexer.
typedef struct {
  logic [2:0]  kind;
  logic [11:0] start_res;
  logic [12:0] length;
  logic [62:0] int_value;
  logic [15:0] punc_text;
} token_t;

// Predicts the tokens of the accepted bytes and checks the token words against them.
class token_scoreboard;
  int          line_max;
  scan_mode_t  mode;
  logic [11:0] pos;
  logic [11:0] tok_start;
  logic [7:0]  prev;
  logic [62:0] acc;
  logic [3:0]  kw;
  logic [15:0] sym;
  bit          skip;
  token_t      expected_tokens[$];
  int          errors;

  function new(int line_limit);
    line_max = line_limit;
    errors = 0;
    clear();
  endfunction

  function void clear();
    mode = SCAN_IDLE;
    pos = '0;
    tok_start = '0;
    prev = '0;
    acc = '0;
    kw = KW_START;
    sym = '0;
    skip = 1'b0;
  endfunction

  static function bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  static function bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  static function bit is_word_byte(logic [7:0] c);
    return is_letter(c) || is_num(c) || c == CH_UNDER;
  endfunction

  // Prefix tracker: extern walks 1..6, def walks 7..9, full matches and misses hold.
  function logic [3:0] keyword_step(logic [3:0] p, logic [7:0] c);
    string ext_word = "extern";
    string def_word = "def";
    if (p == KW_START)
      return (c == ext_word[0]) ? KW_START + 4'd1 : ((c == def_word[0]) ? KW_DEF_FIRST : KW_NONE);
    if (p > KW_START && p < KW_EXTERN_FULL)
      return (c == ext_word[p]) ? p + 4'd1 : KW_NONE;
    if (p >= KW_DEF_FIRST && p < KW_DEF_FULL)
      return (c == def_word[p - KW_DEF_FIRST + 4'd1]) ? p + 4'd1 : KW_NONE;
    return p;
  endfunction

  // A byte seen in idle may open a new token.
  function void open_token(logic [7:0] c);
    mode = SCAN_IDLE;
    tok_start = pos;
    if (is_letter(c) || c == CH_UNDER) begin
      mode = SCAN_IDENT;
      kw = keyword_step(KW_START, c);
    end else if (is_num(c)) begin
      mode = SCAN_INT;
      acc = 63'(c - "0");
    end else if (c == CH_QUOTE) begin
      mode = SCAN_STR;
    end else if (c == CH_HASH) begin
      skip = 1'b1;
    end else if (c != CH_SPACE) begin
      mode = SCAN_SYM;
      sym = {c, 8'h00};
    end
  endfunction

  function void push_token(kind_t k, logic [12:0] len, logic [62:0] v, logic [15:0] p);
    token_t t;
    t.kind = k;
    t.start_res = tok_start;
    t.length = len;
    t.int_value = v;
    t.punc_text = p;
    expected_tokens.push_back(t);
  endfunction

  // Called for every accepted byte word.
  function void note_byte(logic [7:0] c, logic last);
    logic [12:0] span;
    logic [63:0] digit;
    kind_t       k;
    span = {1'b0, pos} - {1'b0, tok_start};
    if (!skip) begin
      case (mode)
        SCAN_IDENT: begin
          if (!is_word_byte(c)) begin
            k = (kw == KW_EXTERN_FULL) ? KIND_EXTERN : ((kw == KW_DEF_FULL) ? KIND_DEF : KIND_IDENT);
            push_token(k, span, '0, '0);
            open_token(c);
          end else begin
            kw = keyword_step(kw, c);
          end
        end
        SCAN_INT: begin
          if (c == CH_DOT) begin
            mode = SCAN_DEC;
          end else if (is_num(c)) begin
            // Saturate instead of wrapping.
            digit = 64'(c - "0");
            if ({1'b0, acc} > ({1'b0, ACC_MAX} - digit) / 10)
              acc = ACC_MAX;
            else
              acc = 63'({1'b0, acc} * 10 + digit);
          end else begin
            push_token(KIND_INT, span, acc, '0);
            open_token(c);
          end
        end
        SCAN_DEC: begin
          if (!is_num(c)) begin
            push_token(KIND_DEC, span, '0, '0);
            open_token(c);
          end
        end
        SCAN_STR: begin
          // The closing quote belongs to the string token.
          if (c == CH_QUOTE && prev != CH_BACKSLASH) begin
            push_token(KIND_STR, span + 13'd1, '0, '0);
            mode = SCAN_IDLE;
          end
        end
        SCAN_SYM: begin
          if (is_word_byte(c) || c == CH_NEWLINE) begin
            push_token((span > 13'd2) ? KIND_SYM_LONG : KIND_PUNC, span, '0, sym);
            open_token(c);
          end else if (span == 13'd1) begin
            sym = sym | {8'h00, c};
          end
        end
        default: open_token(c);
      endcase
    end
    prev = c;
    if (pos < line_max - 1)
      pos = pos + 12'd1;
    if (last)
      clear();
  endfunction

  // Called for every accepted token word.
  function void check_token(token_t got);
    token_t want;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token: kind %0d start %0d length %0d",
             got.kind, got.start_res, got.length);
      errors++;
      return;
    end
    want = expected_tokens.pop_front();
    if (got.kind !== want.kind) begin
      $error("kind: expected %0d, got %0d", want.kind, got.kind);
      errors++;
    end
    if (got.start_res !== want.start_res) begin
      $error("start_res: expected %0d, got %0d", want.start_res, got.start_res);
      errors++;
    end
    if (got.length !== want.length) begin
      $error("length: expected %0d, got %0d", want.length, got.length);
      errors++;
    end
    if (got.int_value !== want.int_value) begin
      $error("int_value: expected %0h, got %0h", want.int_value, got.int_value);
      errors++;
    end
    if (got.punc_text !== want.punc_text) begin
      $error("punc_text: expected %0h, got %0h", want.punc_text, got.punc_text);
      errors++;
    end
  endfunction
endclass

module line_token_lexer_tb;
  localparam int LINE_LIMIT = 4096;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_req = 1'b0;
  logic calm = 1'b0;

  ltl_in_if  text_if ();
  ltl_out_if token_if ();

  token_scoreboard sb;
  token_t          seen_token;
  logic [7:0]      line_bytes[$];
  int              bytes_sent = 0;
  int              target;
  int              hold_left = 0;
  bit              hold_done = 1'b0;

  line_token_lexer #(.LINE_MAX(LINE_LIMIT)) i_dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_if),
    .token (token_if)
  );

  initial forever #2 clk = ~clk;

  // Watchdog for a hung handshake.
  initial begin
    #4_000_000;
    $display("line_token_lexer_tb NOT OK");
    $finish;
  end

  // Token receiver: random back-pressure, one long hold-off on request, none when calm.
  initial begin
    token_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        token_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        token_if.ready <= 1'b0;
      end else begin
        token_if.ready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Monitor: byte words feed the predictor, token words are checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (text_if.valid && text_if.ready)
        sb.note_byte(text_if.ch, text_if.line_last);
      if (token_if.valid && token_if.ready) begin
        seen_token.kind = token_if.kind;
        seen_token.start_res = token_if.start_res;
        seen_token.length = token_if.length;
        seen_token.int_value = token_if.int_value;
        seen_token.punc_text = token_if.punc_text;
        sb.check_token(seen_token);
      end
    end
  end

  function automatic logic [7:0] pick_word_byte();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return CH_UNDER;
  endfunction

  // Any non-word byte, newline included; common punctuation is favored.
  function automatic logic [7:0] pick_symbol_byte();
    string      marks = "+-*/=<>()[]{},;:!&|~^%@$?'`.\n\"# \\";
    logic [7:0] c;
    if ($urandom_range(0, 1))
      return marks[$urandom_range(0, marks.len() - 1)];
    do c = 8'($urandom_range(0, 255));
    while (is_word(c));
    return c;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++)
      line_bytes.push_back(s[i]);
  endfunction

  // Appends one lexical piece with random content to the line being built.
  function automatic void add_piece(bit allow_comment);
    int    r;
    int    n;
    string ext_word = "extern";
    string def_word = "def";
    r = $urandom_range(0, 99);
    if (r < 25) begin
      n = $urandom_range(0, 99);
      if (n < 20)
        put_text(ext_word.substr(0, $urandom_range(0, 5)));
      else if (n < 35)
        put_text(def_word.substr(0, $urandom_range(0, 2)));
      else
        line_bytes.push_back(($urandom_range(0, 52) == 52) ? CH_UNDER : pick_word_byte() | 8'h40);
      repeat ($urandom_range(0, 5)) line_bytes.push_back(pick_word_byte());
    end else if (r < 45) begin
      // Integers, some long enough to saturate, some turned into decimals.
      n = ($urandom_range(0, 99) < 12) ? $urandom_range(19, 22) : $urandom_range(1, 4);
      if ($urandom_range(0, 1) && n > 18)
        repeat (n) line_bytes.push_back("9");
      else
        repeat (n) line_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      if ($urandom_range(0, 99) < 25) begin
        line_bytes.push_back(CH_DOT);
        repeat ($urandom_range(0, 3)) line_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      end
    end else if (r < 55) begin
      // Strings with escaped and bare quotes inside.
      line_bytes.push_back(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        n = $urandom_range(0, 99);
        if (n < 20) line_bytes.push_back(CH_BACKSLASH);
        else if (n < 30) line_bytes.push_back(CH_QUOTE);
        else line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 85)
        line_bytes.push_back(CH_QUOTE);
    end else if (r < 72) begin
      repeat ($urandom_range(1, 4)) line_bytes.push_back(pick_symbol_byte());
    end else if (r < 87 || (r < 92 && !allow_comment)) begin
      repeat ($urandom_range(1, 2)) line_bytes.push_back(CH_SPACE);
    end else if (r < 92) begin
      line_bytes.push_back(CH_HASH);
      repeat ($urandom_range(0, 5)) line_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      line_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // Offers one byte word, with an occasional gap before it.
  task automatic send_byte(logic [7:0] c, logic last);
    if (!calm && $urandom_range(0, 99) < 7) begin
      text_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    text_if.valid <= 1'b1;
    text_if.ch <= c;
    text_if.line_last <= last;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends the built line, marking its final byte.
  task automatic send_line();
    for (int i = 0; i < line_bytes.size(); i++)
      send_byte(line_bytes[i], i == line_bytes.size() - 1);
    line_bytes.delete();
  endtask

  task automatic send_random_line(int len, bit allow_comment);
    while (line_bytes.size() < len) add_piece(allow_comment);
    send_line();
  endtask

  task automatic send_short_lines(int upto);
    while (bytes_sent < upto)
      send_random_line(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 24), 1'b1);
  endtask

  // Stops offering bytes until every predicted token has been taken.
  task automatic drain();
    text_if.valid <= 1'b0;
    do @(posedge clk);
    while (sb.expected_tokens.size() != 0);
  endtask

  initial begin
    sb = new(LINE_LIMIT);
    text_if.valid = 1'b0;
    text_if.ch = '0;
    text_if.line_last = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Keyword, decimal, and a symbol dropped at the end of the line.
    put_text("extern 1.5(");
    send_line();
    // Def keyword, over-long symbol, underscore identifier, comment.
    put_text("def+=!_a#q");
    send_line();
    // Empty and escaped strings, a newline-ended symbol with extreme bytes,
    // a hash inside a symbol, an integer dropped at the end of the line.
    put_text("\"\"\"\\\"\"\n");
    line_bytes.push_back(8'hFF);
    line_bytes.push_back(8'h00);
    put_text("\n#9");
    send_line();

    send_short_lines(600);

    // The receiver holds off for a long stretch while bytes keep coming.
    hold_req <= 1'b1;
    send_short_lines(800);
    drain();

    // No idling on either side.
    calm <= 1'b1;
    send_short_lines(1200);
    calm <= 1'b0;

    target = bytes_sent + 550;
    send_short_lines(target);
    drain();
    repeat (8) @(posedge clk);

    if (sb.errors == 0)
      $display("line_token_lexer_tb OK");
    else
      $display("line_token_lexer_tb NOT OK");
    $finish;
  end
endmodule
